/* rtl/lcmv_pkg.sv */
// ----------------------------------------------------------------------------
// lcmv_pkg: shared types and constants for the lc meter value calculation
// Widths, the divisor floor, the two scale factors and the cell payload type.
// ----------------------------------------------------------------------------
package lcmv_pkg;

   localparam int unsigned CountWidth  = 16;
   localparam int unsigned NumWidth    = 32;  // ref*ref
   localparam int unsigned ProdWidth   = 43;  // (ref*ref/meas)*K
   localparam int unsigned ResultWidth = 32;
   localparam int unsigned KWidth      = 11;

   localparam logic [CountWidth-1:0] MinDivisor   = 16'd65;
   localparam logic [KWidth-1:0]     KCapacitance = 11'd2000;
   localparam logic [KWidth-1:0]     KInductance  = 11'd1000;

   typedef enum logic {
      OP_CAPACITANCE = 1'b0,
      OP_INDUCTANCE  = 1'b1
   } op_type;

   // word carried between cells of one divider row
   typedef struct packed {
      logic                  valid;
      logic [ProdWidth-1:0]  rem;    // partial remainder
      logic [ProdWidth-1:0]  num;    // dividend bits still to shift in
      logic [ProdWidth-1:0]  quo;    // quotient bits so far
      logic [CountWidth-1:0] div;
      logic [KWidth-1:0]     k;
   } cell_word_type;

endpackage

/* rtl/lcmv_div_cell.sv */
// ----------------------------------------------------------------------------
// lcmv_div_cell: one restoring division step
// Shifts one dividend bit into the remainder, trial subtracts the divisor,
// and registers the word when the row advances.
// ----------------------------------------------------------------------------
module lcmv_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  lcmv_pkg::cell_word_type word_i,
   output lcmv_pkg::cell_word_type word_o
);
   import lcmv_pkg::*;

   cell_word_type          word_ff, word_in;
   logic [ProdWidth:0]     shifted;
   logic [ProdWidth:0]     diff;

   // shift and trial subtract
   always_comb begin
      word_in = word_i;
      shifted = {word_i.rem, word_i.num[ProdWidth-1]};
      diff    = shifted - {{(ProdWidth+1-CountWidth){1'b0}}, word_i.div};
      word_in.num = {word_i.num[ProdWidth-2:0], 1'b0};
      if (!diff[ProdWidth]) begin
         word_in.rem = diff[ProdWidth-1:0];
         word_in.quo = {word_i.quo[ProdWidth-2:0], 1'b1};
      end else begin
         word_in.rem = shifted[ProdWidth-1:0];
         word_in.quo = {word_i.quo[ProdWidth-2:0], 1'b0};
      end
   end

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff.valid <= word_in.valid;
      end
      if (advance) begin
         word_ff.rem <= word_in.rem;
         word_ff.num <= word_in.num;
         word_ff.quo <= word_in.quo;
         word_ff.div <= word_in.div;
         word_ff.k   <= word_in.k;
      end
   end

   assign word_o = word_ff;

endmodule

/* rtl/lcmv_div_row.sv */
// ----------------------------------------------------------------------------
// lcmv_div_row: chain of division cells
// Depth cells, each giving one quotient bit of a dividend of Depth bits.
// ----------------------------------------------------------------------------
module lcmv_div_row #(
   parameter int unsigned Depth = lcmv_pkg::ProdWidth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  lcmv_pkg::cell_word_type word_i,
   output lcmv_pkg::cell_word_type word_o
);
   import lcmv_pkg::*;

   cell_word_type link [Depth+1];

   assign link[0] = word_i;

   // one cell per quotient bit
   for (genvar i = 0; i < Depth; i++) begin : g_cell
      lcmv_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .word_i  (link[i]),
         .word_o  (link[i+1])
      );
   end

   assign word_o = link[Depth];

endmodule

/* rtl/lc_meter_value_calc.sv */
// ----------------------------------------------------------------------------
// lc_meter_value_calc: lc meter component value from gate counts
// Clamps the measured count, then ((ref*ref/meas)*K)/meas - K through two
// rows of restoring division cells with a multiply stage between them.
// Stages in order: input register, first row cells, multiply register, second row cells, result register.
// Throughput: one word per cycle while the chain advances; every cell then passes its word on.
// The whole chain stalls only when the result register is full and stalled.
// Reset clears all valid flags and the reference count to zero.
// ----------------------------------------------------------------------------
module lc_meter_value_calc (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [lcmv_pkg::CountWidth-1:0]     csr_write_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [lcmv_pkg::CountWidth-1:0]     req_measured_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lcmv_pkg::ResultWidth-1:0] rsp_component_value
);
   import lcmv_pkg::*;

   logic [CountWidth-1:0] ref_ff;
   logic                  advance;
   logic                  in_valid_ff;
   logic [CountWidth-1:0] in_div_ff, clamped;
   logic [KWidth-1:0]     in_k_ff;
   logic [NumWidth-1:0]   sq_ff;
   cell_word_type         row1_in, row1_out, row2_in, row2_out;
   cell_word_type         mul_ff, mul_in;
   logic                  out_valid_ff;
   logic [ResultWidth-1:0] out_value_ff, out_value_in;

   // reference count register
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '0;
      end else if (csr_write_enable) begin
         ref_ff <= csr_write_data;
      end
   end

   // whole chain moves unless the result is held
   assign advance   = !(out_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // clamp the divisor
   always_comb begin
      clamped = (req_measured_count > ref_ff) ? ref_ff : req_measured_count;
      if (clamped < MinDivisor) begin
         clamped = MinDivisor;
      end
   end

   // input stage: clamp and square
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
      if (advance) begin
         in_div_ff <= clamped;
         in_k_ff   <= (op_type'(req_operation) == OP_INDUCTANCE) ? KInductance
                                                                 : KCapacitance;
         sq_ff     <= NumWidth'(ref_ff) * NumWidth'(ref_ff);
      end
   end

   // first division: ref*ref / meas
   always_comb begin
      row1_in       = '0;
      row1_in.valid = in_valid_ff;
      row1_in.num   = {sq_ff, {(ProdWidth-NumWidth){1'b0}}};
      row1_in.div   = in_div_ff;
      row1_in.k     = in_k_ff;
   end

   lcmv_div_row #(.Depth(NumWidth)) u_row1 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word_i  (row1_in),
      .word_o  (row1_out)
   );

   // scale by K
   always_comb begin
      mul_in     = row1_out;
      mul_in.rem = '0;
      mul_in.quo = '0;
      mul_in.num = {{(ProdWidth-NumWidth){1'b0}}, row1_out.quo[NumWidth-1:0]}
                 * {{(ProdWidth-KWidth){1'b0}}, row1_out.k};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid <= 1'b0;
      end else if (advance) begin
         mul_ff.valid <= mul_in.valid;
      end
      if (advance) begin
         mul_ff.rem <= mul_in.rem;
         mul_ff.num <= mul_in.num;
         mul_ff.quo <= mul_in.quo;
         mul_ff.div <= mul_in.div;
         mul_ff.k   <= mul_in.k;
      end
   end

   assign row2_in = mul_ff;

   // second division: product / meas
   lcmv_div_row #(.Depth(ProdWidth)) u_row2 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word_i  (row2_in),
      .word_o  (row2_out)
   );

   // subtract K into the result register
   assign out_value_in = row2_out.quo[ResultWidth-1:0]
                       - {{(ResultWidth-KWidth){1'b0}}, row2_out.k};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= row2_out.valid;
      end
      if (advance) begin
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_component_value = out_value_ff;

   // held result does not change
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_component_value)))
      else $error("held result changed");

   // result never below -KCapacitance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_component_value) >= -32'sd2000))
      else $error("result below minimum");

   // divisor in the chain never below the floor
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (in_div_ff >= MinDivisor))
      else $error("divisor below floor");

   // input stalled only when result held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("stall without held result");

endmodule

/* tb/sv/tb_lc_meter_value_calc.sv */
// ----------------------------------------------------------------------------
// tb_lc_meter_value_calc: self-checking bench for the lc meter value block
// Drives measured counts under several reference settings, predicts each
// component value and compares every result word in order, with random
// idling on both sides and a long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_lc_meter_value_calc;
   import lcmv_pkg::*;

   localparam int Latency = 78;

   logic                         clock;
   logic                         reset;
   logic                         csr_write_enable;
   logic [CountWidth-1:0]        csr_write_data;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_operation;
   logic [CountWidth-1:0]        req_measured_count;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [ResultWidth-1:0] rsp_component_value;

   logic [CountWidth-1:0]        reference_setting;
   logic [ResultWidth-1:0]       expected_values[$];
   int                           error_count;
   bit                           idle_enable;
   int                           hold_off_cycles;

   lc_meter_value_calc DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_measured_count  (req_measured_count),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_component_value (rsp_component_value)
   );

   // clock
   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   // component value for one word at the current reference
   function automatic logic [ResultWidth-1:0] component_value(op_type op,
                                                              logic [CountWidth-1:0] meas);
      logic [63:0] divisor;
      logic [63:0] scale;
      logic [63:0] quotient;
      divisor = 64'(meas);
      scale = (op == OP_INDUCTANCE) ? 64'd1000 : 64'd2000;
      if (divisor > 64'(reference_setting)) divisor = 64'(reference_setting);
      if (divisor < 64'd65) divisor = 64'd65;
      quotient = (64'(reference_setting) * 64'(reference_setting)) / divisor;
      quotient = (quotient * scale) / divisor;
      return ResultWidth'(quotient - scale);
   endfunction

   // send one word, holding it until accepted
   task automatic send_word(op_type op, logic [CountWidth-1:0] meas);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_measured_count <= meas;
      expected_values.push_back(component_value(op, meas));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_values.size() != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
   endtask

   task automatic write_reference(logic [CountWidth-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      reference_setting = value;
   endtask

   // result side stall bursts and hold-offs
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_values.size() == 0) begin
            $error("unexpected result word component_value=%0d", rsp_component_value);
            error_count++;
         end else begin
            if (rsp_component_value !== expected_values[0]) begin
               $error("component_value expected %0d actual %0d",
                      $signed(expected_values[0]), rsp_component_value);
               error_count++;
            end
            void'(expected_values.pop_front());
         end
      end
   end

   // extremes of the count and reference, both operations
   task automatic test_directed();
      logic [CountWidth-1:0] refs[5];
      refs = '{16'd0, 16'd64, 16'd65, 16'd1000, 16'hFFFF};
      foreach (refs[i]) begin
         write_reference(refs[i]);
         send_word(OP_CAPACITANCE, 16'd0);
         send_word(OP_INDUCTANCE, 16'd0);
         send_word(OP_CAPACITANCE, 16'd65);
         send_word(OP_INDUCTANCE, 16'hFFFF);
         send_word(OP_CAPACITANCE, refs[i]);
      end
   endtask

   // random words, mostly counts below the reference
   task automatic test_random(int count);
      logic [CountWidth-1:0] meas;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 3))
            0: meas = 16'($urandom);
            1: meas = 16'($urandom_range(0, 100));
            default: meas = 16'($urandom_range(0, reference_setting));
         endcase
         send_word(op_type'(1'($urandom_range(0, 1))), meas);
      end
   endtask

   // result side held off so the pipeline fills and stalls its input
   task automatic test_back_pressure();
      drain_results();
      @(posedge clock);
      hold_off_cycles = 300;
      @(negedge clock);
      test_random(150);
      drain_results();
   endtask

   initial begin
      error_count        = 0;
      idle_enable        = 1'b0;
      hold_off_cycles    = 0;
      reference_setting  = '0;
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      req_valid          = 1'b0;
      req_operation      = 1'b0;
      req_measured_count = '0;
      rsp_stall          = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_directed();
      idle_enable = 1'b1;
      write_reference(16'hFFFF);
      test_random(300);
      write_reference(16'($urandom));
      test_random(300);
      write_reference(16'($urandom_range(0, 200)));
      test_random(200);
      write_reference(16'($urandom));
      test_back_pressure();
      write_reference(16'($urandom));
      test_random(300);
      idle_enable = 1'b0;
      write_reference(16'($urandom_range(1000, 65535)));
      test_random(275);
      drain_results();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // timeout
   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* files.f */
rtl/lcmv_pkg.sv
rtl/lcmv_div_cell.sv
rtl/lcmv_div_row.sv
rtl/lc_meter_value_calc.sv
tb/sv/tb_lc_meter_value_calc.sv
